// ===== rtl/btbm_pkg.sv =====
// Shared types and constants for the binary template best-match block.
package btbm_pkg;

    // Default sizes
    localparam int TEMPLATE_COUNT_DEF = 64;
    localparam int BITMAP_BITS_DEF    = 64;

    // Fixed field widths
    localparam int CMD_W     = 1;
    localparam int INDEX_W   = 6;
    localparam int LABEL_W   = 8;
    localparam int BITMAP_W  = 64;
    localparam int SCORE_W   = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Register file indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMPLATES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_USE      = 2'd1;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] TEMPLATES_IN_USE_RST = 7'd64;
    localparam logic [CFG_W-1:0] BITS_IN_USE_RST      = 7'd64;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 1'b0,
        CMD_MATCH = 1'b1
    } btbm_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } btbm_state_t;

    // Sequencer to scoring unit
    typedef struct packed {
        logic clear;    // start of a match, drop running best
        logic rd_vld;   // template memory read data valid this cycle
    } btbm_scan_ctl_t;

    // Scoring unit to sequencer
    typedef struct packed {
        logic               busy;
        logic [SCORE_W-1:0] best_score;
        logic [LABEL_W-1:0] best_label;
    } btbm_scan_sts_t;

endpackage

// ===== rtl/btbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module btbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/btbm_score.sv =====
// Shared scoring unit: masked agreement popcount and running best per candidate.
module btbm_score #(
    parameter int BITMAP_BITS = btbm_pkg::BITMAP_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  btbm_pkg::btbm_scan_ctl_t ctl,
    input  logic [BITMAP_BITS-1:0]   tmpl_bits,
    input  logic [btbm_pkg::LABEL_W-1:0] tmpl_label,
    input  logic [BITMAP_BITS-1:0]   cand,
    input  logic [BITMAP_BITS-1:0]   mask,
    output btbm_pkg::btbm_scan_sts_t sts
);
    import btbm_pkg::*;

    localparam int NG  = (BITMAP_BITS + 7) / 8;
    localparam int PW  = NG * 8;
    localparam int SW  = $clog2(BITMAP_BITS + 1);

    logic [PW-1:0]      agree;
    logic [3:0]         byte_cnt      [NG];
    logic [3:0]         byte_cnt_reg  [NG];
    logic [LABEL_W-1:0] a_label_reg;
    logic               a_vld_reg;
    logic [SW-1:0]      score;
    logic [SW-1:0]      score_reg;
    logic [LABEL_W-1:0] b_label_reg;
    logic               b_vld_reg;
    logic [SW-1:0]      best_score_reg;
    logic [LABEL_W-1:0] best_label_reg;

    // Bits that agree, restricted to bits in use, padded to whole bytes
    assign agree = PW'(~(cand ^ tmpl_bits) & mask);

    // Stage A: per-byte ones count
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            byte_cnt[g] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                byte_cnt[g] = byte_cnt[g] + 4'(agree[g*8 + b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NG; g++) begin
            byte_cnt_reg[g] <= byte_cnt[g];
        end
        a_label_reg <= tmpl_label;
    end

    // Stage B: sum of byte counts
    always_comb begin
        score = '0;
        for (int g = 0; g < NG; g++) begin
            score = score + SW'(byte_cnt_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        score_reg   <= score;
        b_label_reg <= a_label_reg;
    end

    // Valid tracking through the two stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= ctl.rd_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    // Stage C: first template with a strictly higher score wins
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= '0;
            best_label_reg <= '0;
        end else if (ctl.clear) begin
            best_score_reg <= '0;
            best_label_reg <= '0;
        end else if (b_vld_reg && (score_reg > best_score_reg)) begin
            best_score_reg <= score_reg;
            best_label_reg <= b_label_reg;
        end
    end

    assign sts.busy       = a_vld_reg | b_vld_reg;
    assign sts.best_score = SCORE_W'(best_score_reg);
    assign sts.best_label = best_label_reg;

endmodule

// ===== rtl/btbm_ctrl.sv =====
// Sequencer: request intake, register file, template scan, group tracking and result register.
module btbm_ctrl #(
    parameter int TEMPLATE_COUNT = btbm_pkg::TEMPLATE_COUNT_DEF,
    parameter int BITMAP_BITS    = btbm_pkg::BITMAP_BITS_DEF,
    parameter int AW             = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [btbm_pkg::CMD_W-1:0]         s_command,
    input  logic [btbm_pkg::INDEX_W-1:0]       s_template_index,
    input  logic [btbm_pkg::LABEL_W-1:0]       s_template_label,
    input  logic [btbm_pkg::BITMAP_W-1:0]      s_bitmap,
    input  logic                               s_last_in_group,
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [btbm_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [btbm_pkg::CFG_W-1:0]         cfg_wr_data,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [btbm_pkg::LABEL_W-1:0]       m_best_label,
    output logic [btbm_pkg::SCORE_W-1:0]       m_best_score,
    // template memory
    output logic                               mem_wr_en,
    output logic [AW-1:0]                      mem_wr_addr,
    output logic [BITMAP_BITS+btbm_pkg::LABEL_W-1:0] mem_wr_data,
    output logic                               mem_rd_en,
    output logic [AW-1:0]                      mem_rd_addr,
    // scoring unit
    output btbm_pkg::btbm_scan_ctl_t           scan_ctl,
    input  btbm_pkg::btbm_scan_sts_t           scan_sts,
    output logic [BITMAP_BITS-1:0]             cand,
    output logic [BITMAP_BITS-1:0]             mask
);
    import btbm_pkg::*;

    localparam int CW = $clog2(TEMPLATE_COUNT + 1);

    btbm_state_t        state_reg, state_next;
    logic [CFG_W-1:0]   tiu_reg, tiu_next;
    logic [CFG_W-1:0]   biu_reg, biu_next;
    logic [CW-1:0]      nt_reg, nt_next;
    logic [CW-1:0]      issue_cnt_reg, issue_cnt_next;
    logic               rd_vld_reg;
    logic [BITMAP_BITS-1:0] cand_reg;
    logic [BITMAP_BITS-1:0] mask_reg, mask_next;
    logic               last_reg;
    logic               group_open_reg, group_open_next;
    logic [SCORE_W-1:0] group_score_reg, group_score_next;
    logic [LABEL_W-1:0] group_label_reg, group_label_next;
    logic               m_valid_reg, m_valid_next;
    logic [LABEL_W-1:0] m_label_reg, m_label_next;
    logic [SCORE_W-1:0] m_score_reg, m_score_next;
    logic [CFG_W-1:0]   nb;

    logic accept, match_start, issue, scan_done, finish, take;

    assign accept      = s_valid && s_ready;
    assign match_start = accept && (s_command == CMD_MATCH);

    // Template store writes on load requests inside the store
    assign mem_wr_en   = accept && (s_command == CMD_LOAD)
                         && (32'(s_template_index) < TEMPLATE_COUNT);
    assign mem_wr_addr = AW'(s_template_index);
    assign mem_wr_data = {s_template_label, s_bitmap[BITMAP_BITS-1:0]};

    // Register file
    always_comb begin
        tiu_next = tiu_reg;
        biu_next = biu_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_TEMPLATES_IN_USE: tiu_next = cfg_wr_data;
                REG_BITS_IN_USE:      tiu_next = tiu_reg;
                default:              tiu_next = tiu_reg;
            endcase
            case (cfg_wr_index)
                REG_BITS_IN_USE: biu_next = cfg_wr_data;
                default:         biu_next = biu_reg;
            endcase
        end
    end

    // Saturated template count and bit mask taken at match start
    always_comb begin
        if (32'(tiu_reg) > TEMPLATE_COUNT) begin
            nt_next = CW'(TEMPLATE_COUNT);
        end else begin
            nt_next = CW'(tiu_reg);
        end
        if (32'(biu_reg) > BITMAP_BITS) begin
            nb = CFG_W'(BITMAP_BITS);
        end else begin
            nb = biu_reg;
        end
        for (int i = 0; i < BITMAP_BITS; i++) begin
            mask_next[i] = (i < int'(nb));
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (match_start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready   = 1'b0;
        issue     = 1'b0;
        scan_done = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: begin
                issue     = (issue_cnt_reg < nt_reg);
                scan_done = !issue && !rd_vld_reg && !scan_sts.busy;
            end
            ST_DONE: finish = !last_reg || !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // Group update and result register
    always_comb begin
        take             = !group_open_reg || (scan_sts.best_score > group_score_reg);
        group_open_next  = group_open_reg;
        group_score_next = group_score_reg;
        group_label_next = group_label_reg;
        m_label_next     = m_label_reg;
        m_score_next     = m_score_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (finish) begin
            if (last_reg) begin
                m_valid_next     = 1'b1;
                m_score_next     = take ? scan_sts.best_score : group_score_reg;
                m_label_next     = take ? scan_sts.best_label : group_label_reg;
                group_open_next  = 1'b0;
                group_score_next = '0;
                group_label_next = '0;
            end else begin
                group_open_next = 1'b1;
                if (take) begin
                    group_score_next = scan_sts.best_score;
                    group_label_next = scan_sts.best_label;
                end
            end
        end
    end

    // Scan address counter
    always_comb begin
        issue_cnt_next = issue_cnt_reg;
        if (match_start) begin
            issue_cnt_next = '0;
        end else if (issue) begin
            issue_cnt_next = issue_cnt_reg + CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            tiu_reg         <= TEMPLATES_IN_USE_RST;
            biu_reg         <= BITS_IN_USE_RST;
            issue_cnt_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            group_open_reg  <= 1'b0;
            group_score_reg <= '0;
            group_label_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tiu_reg         <= tiu_next;
            biu_reg         <= biu_next;
            issue_cnt_reg   <= issue_cnt_next;
            rd_vld_reg      <= issue;
            group_open_reg  <= group_open_next;
            group_score_reg <= group_score_next;
            group_label_reg <= group_label_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Request payload and result payload
    always_ff @(posedge aclk) begin
        if (match_start) begin
            nt_reg   <= nt_next;
            cand_reg <= s_bitmap[BITMAP_BITS-1:0];
            mask_reg <= mask_next;
            last_reg <= s_last_in_group;
        end
        m_label_reg <= m_label_next;
        m_score_reg <= m_score_next;
    end

    assign mem_rd_en       = issue;
    assign mem_rd_addr     = issue_cnt_reg[AW-1:0];
    assign scan_ctl.clear  = match_start;
    assign scan_ctl.rd_vld = rd_vld_reg;
    assign cand            = cand_reg;
    assign mask            = mask_reg;
    assign m_valid         = m_valid_reg;
    assign m_best_label    = m_label_reg;
    assign m_best_score    = m_score_reg;

endmodule

// ===== rtl/binary_template_best_match_core.sv =====
// Binary template best-match core: top level.
//
// Requests arrive on the s_ channel (valid/ready). A load request (s_command = 0)
// writes s_bitmap and s_template_label into slot s_template_index of the template
// store and leaves the block idle. A match request (s_command = 1) scans templates
// 0 .. n-1, n = min(templates_in_use, TEMPLATE_COUNT), one per cycle through a
// shared popcount unit fed by the template memory read port. s_ready stays low
// through the scan and done states, so the next request is taken only once the
// last template has been scored and the sequencer is idle again.
// The match request flagged with s_last_in_group yields one result on the m_
// channel: the label and agreement count of the group's best template.
// The result sits in an output register, so the next request is taken while it
// waits; only a further group end stalls until m_ready takes the earlier result.
// Registers are written through cfg_wr_en / cfg_wr_index / cfg_wr_data; the user
// must write them only while idle, as the block itself does not enforce it.
// Reset (aresetn low, synchronous) closes any open group, drops a pending result
// and restores templates_in_use = 64 and bits_in_use = 64. Template memory
// contents are not cleared; slots must be loaded before they are matched.
module binary_template_best_match_core #(
    parameter int TEMPLATE_COUNT = btbm_pkg::TEMPLATE_COUNT_DEF,
    parameter int BITMAP_BITS    = btbm_pkg::BITMAP_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [btbm_pkg::CMD_W-1:0]     s_command,
    input  logic [btbm_pkg::INDEX_W-1:0]   s_template_index,
    input  logic [btbm_pkg::LABEL_W-1:0]   s_template_label,
    input  logic [btbm_pkg::BITMAP_W-1:0]  s_bitmap,
    input  logic                           s_last_in_group,
    input  logic                           cfg_wr_en,
    input  logic [btbm_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [btbm_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [btbm_pkg::LABEL_W-1:0]   m_best_label,
    output logic [btbm_pkg::SCORE_W-1:0]   m_best_score
);
    import btbm_pkg::*;

    localparam int AW = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1;
    localparam int DW = BITMAP_BITS + LABEL_W;

    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [DW-1:0]          mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [DW-1:0]          mem_rd_data;
    btbm_scan_ctl_t         scan_ctl;
    btbm_scan_sts_t         scan_sts;
    logic [BITMAP_BITS-1:0] cand;
    logic [BITMAP_BITS-1:0] mask;

    // Sequencer
    btbm_ctrl #(
        .TEMPLATE_COUNT (TEMPLATE_COUNT),
        .BITMAP_BITS    (BITMAP_BITS),
        .AW             (AW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_template_index (s_template_index),
        .s_template_label (s_template_label),
        .s_bitmap         (s_bitmap),
        .s_last_in_group  (s_last_in_group),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_best_label     (m_best_label),
        .m_best_score     (m_best_score),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .scan_ctl         (scan_ctl),
        .scan_sts         (scan_sts),
        .cand             (cand),
        .mask             (mask)
    );

    // Template store: {label, bits} per slot
    btbm_ram #(
        .WIDTH (DW),
        .DEPTH (TEMPLATE_COUNT),
        .AW    (AW)
    ) u_tmpl_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Shared scoring unit
    btbm_score #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_score (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .tmpl_bits  (mem_rd_data[BITMAP_BITS-1:0]),
        .tmpl_label (mem_rd_data[DW-1:BITMAP_BITS]),
        .cand       (cand),
        .mask       (mask),
        .sts        (scan_sts)
    );

endmodule

// ===== rtl/btbm_checker.sv =====
// Port-level checker for the binary template best-match core, bound to the top level.
module btbm_checker #(
    parameter int BITMAP_BITS = btbm_pkg::BITMAP_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [btbm_pkg::CMD_W-1:0]   s_command,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [btbm_pkg::LABEL_W-1:0] m_best_label,
    input logic [btbm_pkg::SCORE_W-1:0] m_best_score
);
    import btbm_pkg::*;

    // Reset drops any pending result
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_label) && $stable(m_best_score))
        else $error("result changed while stalled");

    // A load request leaves the block ready in the next cycle
    a_load_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_LOAD) |=> s_ready)
        else $error("not ready after load request");

    // A match request occupies the block
    a_match_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_MATCH) |=> !s_ready)
        else $error("ready right after match request");

    // Score never exceeds the bitmap width
    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_best_score <= SCORE_W'(BITMAP_BITS)))
        else $error("result score out of range");

endmodule

bind binary_template_best_match_core btbm_checker #(
    .BITMAP_BITS (BITMAP_BITS)
) u_btbm_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the binary template best-match core.
module tb;
    import btbm_pkg::*;

    localparam int N_TMPL      = TEMPLATE_COUNT_DEF;
    localparam int N_BITS      = BITMAP_BITS_DEF;
    localparam int MAX_GAP     = 18;
    localparam int SETTLE_CYC  = 100;   // covers one full scan of all templates in use
    localparam int HOLD_CYC    = 400;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        btbm_cmd_t           command;
        logic [INDEX_W-1:0]  index;
        logic [LABEL_W-1:0]  label;
        logic [BITMAP_W-1:0] bitmap;
        logic                last;
    } request_t;

    typedef struct {
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
    } best_t;

    // DUT signals
    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    btbm_cmd_t            s_command        = CMD_LOAD;
    logic [INDEX_W-1:0]   s_template_index = '0;
    logic [LABEL_W-1:0]   s_template_label = '0;
    logic [BITMAP_W-1:0]  s_bitmap         = '0;
    logic                 s_last_in_group  = 1'b0;
    logic                 cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index     = REG_TEMPLATES_IN_USE;
    logic [CFG_W-1:0]     cfg_wr_data      = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [LABEL_W-1:0]   m_best_label;
    logic [SCORE_W-1:0]   m_best_score;

    // Stimulus and scoreboard
    request_t req_pending[$];
    request_t cur_req;
    best_t    expected_best[$];
    logic     req_taken  = 1'b0;
    logic     resp_taken = 1'b0;
    int       tx_gap     = 0;
    int       rx_gap     = 0;
    int       tx_max_gap = MAX_GAP;
    int       rx_max_gap = MAX_GAP;
    int       hold_req   = 0;
    int       hold_seen  = 0;
    int       hold_left  = 0;
    int       stall_cycles = 0;
    int       n_errors   = 0;

    // Predictor state
    logic [BITMAP_W-1:0] tmpl_bits   [N_TMPL];
    logic [LABEL_W-1:0]  tmpl_labels [N_TMPL];
    logic [SCORE_W-1:0]  grp_score = '0;
    logic [LABEL_W-1:0]  grp_label = '0;
    logic                grp_open  = 1'b0;
    logic [CFG_W-1:0]    cfg_templates = TEMPLATES_IN_USE_RST;
    logic [CFG_W-1:0]    cfg_bits      = BITS_IN_USE_RST;

    // Generator's view of the store, used to aim candidates at real templates
    logic [BITMAP_W-1:0] gen_bits [N_TMPL];

    always #5 aclk = ~aclk;

    binary_template_best_match_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_template_index (s_template_index),
        .s_template_label (s_template_label),
        .s_bitmap         (s_bitmap),
        .s_last_in_group  (s_last_in_group),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_best_label     (m_best_label),
        .m_best_score     (m_best_score)
    );

    // Best-match predictor: updates the store or scores a candidate against the group
    function automatic void predict_request(request_t r);
        int                  n_t;
        int                  n_b;
        int                  sc;
        int                  cand_score;
        logic [LABEL_W-1:0]  cand_label;
        logic [BITMAP_W-1:0] mask;
        best_t               res;
        if (r.command == CMD_LOAD) begin
            if (r.index < N_TMPL) begin
                tmpl_bits[r.index]   = r.bitmap;
                tmpl_labels[r.index] = r.label;
            end
            return;
        end
        n_t = (cfg_templates > N_TMPL) ? N_TMPL : cfg_templates;
        n_b = (cfg_bits > N_BITS) ? N_BITS : cfg_bits;
        mask = (n_b >= 64) ? '1 : ((64'd1 << n_b) - 64'd1);
        cand_score = 0;
        cand_label = '0;
        // first template with the highest agreement count wins
        for (int t = 0; t < n_t; t++) begin
            sc = $countones(~(r.bitmap ^ tmpl_bits[t]) & mask);
            if (sc > cand_score) begin
                cand_score = sc;
                cand_label = tmpl_labels[t];
            end
        end
        // group keeps its first candidate unless beaten strictly
        if (!grp_open || cand_score > grp_score) begin
            grp_score = SCORE_W'(cand_score);
            grp_label = cand_label;
        end
        grp_open = 1'b1;
        if (r.last) begin
            res.label = grp_label;
            res.score = grp_score;
            expected_best.insert(expected_best.size(), res);
            grp_score = '0;
            grp_label = '0;
            grp_open  = 1'b0;
        end
    endfunction

    // Request driver
    always @(negedge aclk) begin
        if (req_taken) tx_gap = $urandom_range(0, tx_max_gap);
        if (!s_valid || req_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (req_pending.size() != 0) begin
                cur_req = req_pending.pop_front();
                s_command        <= cur_req.command;
                s_template_index <= cur_req.index;
                s_template_label <= cur_req.label;
                s_bitmap         <= cur_req.bitmap;
                s_last_in_group  <= cur_req.last;
                s_valid          <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall per result, plus an occasional long hold-off
    always @(negedge aclk) begin
        if (resp_taken) rx_gap = $urandom_range(0, rx_max_gap);
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            if (m_valid) rx_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        best_t want;
        if (!aresetn) begin
            req_taken  <= 1'b0;
            resp_taken <= 1'b0;
        end else begin
            req_taken  <= s_valid && s_ready;
            resp_taken <= m_valid && m_ready;
            if (s_valid && s_ready) predict_request(cur_req);
            if (m_valid && m_ready) begin
                if (expected_best.size() == 0) begin
                    $error("unexpected result: best_label %0d best_score %0d",
                           m_best_label, m_best_score);
                    n_errors++;
                end else begin
                    want = expected_best.pop_front();
                    if (m_best_label !== want.label) begin
                        $error("best_label expected %0d actual %0d", want.label, m_best_label);
                        n_errors++;
                    end
                    if (m_best_score !== want.score) begin
                        $error("best_score expected %0d actual %0d", want.score, m_best_score);
                        n_errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    function automatic logic [BITMAP_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_load(int idx, logic [LABEL_W-1:0] lbl,
                                       logic [BITMAP_W-1:0] bm);
        request_t r;
        r.command = CMD_LOAD;
        r.index   = INDEX_W'(idx);
        r.label   = lbl;
        r.bitmap  = bm;
        r.last    = 1'($urandom_range(0, 1));   // ignored on loads
        gen_bits[idx] = bm;
        req_pending.insert(req_pending.size(), r);
    endfunction

    function automatic void queue_match(logic [BITMAP_W-1:0] bm, logic last);
        request_t r;
        r.command = CMD_MATCH;
        r.index   = INDEX_W'($urandom_range(0, 63));  // ignored on matches
        r.label   = LABEL_W'($urandom_range(0, 255));
        r.bitmap  = bm;
        r.last    = last;
        req_pending.insert(req_pending.size(), r);
    endfunction

    // Mostly well-formed groups aimed near stored templates, some noise
    function automatic void queue_random(int n, int n_active);
        int                  made;
        int                  grp_len;
        int                  slot;
        logic [BITMAP_W-1:0] bm;
        made = 0;
        while (made < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 1)) queue_match(rand64(), 1'($urandom_range(0, 1)));
                    else queue_load($urandom_range(0, N_TMPL - 1),
                                    LABEL_W'($urandom_range(0, 255)), rand64());
                    made++;
                end
                1: begin
                    queue_load($urandom_range(0, N_TMPL - 1), LABEL_W'($urandom_range(0, 255)),
                               rand64());
                    made++;
                end
                default: begin
                    grp_len = $urandom_range(1, 4);
                    for (int k = 0; k < grp_len; k++) begin
                        // load slipped into an open group
                        if ($urandom_range(0, 9) == 0) begin
                            queue_load($urandom_range(0, N_TMPL - 1),
                                       LABEL_W'($urandom_range(0, 255)), rand64());
                            made++;
                        end
                        slot = $urandom_range(0, n_active - 1);
                        case ($urandom_range(0, 3))
                            0:       bm = gen_bits[slot];
                            1, 2:    bm = gen_bits[slot] ^ (rand64() & rand64() & rand64());
                            default: bm = rand64();
                        endcase
                        queue_match(bm, k == grp_len - 1);
                        made++;
                    end
                end
            endcase
        end
    endfunction

    // Wait for an idle block: nothing queued, nothing outstanding, scan drained
    task automatic settle();
        do @(posedge aclk);
        while (req_pending.size() != 0 || s_valid || expected_best.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        if (idx == REG_TEMPLATES_IN_USE) cfg_templates = val;
        else if (idx == REG_BITS_IN_USE) cfg_bits = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int tiu, int biu, int n, bit burst, bit hold);
        int act;
        settle();
        write_reg(REG_TEMPLATES_IN_USE, CFG_W'(tiu));
        write_reg(REG_BITS_IN_USE, CFG_W'(biu));
        tx_max_gap = burst ? 0 : MAX_GAP;
        rx_max_gap = burst ? 0 : MAX_GAP;
        if (hold) hold_req++;
        act = (tiu == 0 || tiu > N_TMPL) ? N_TMPL : tiu;
        queue_random(n, act);
    endtask

    initial begin
        logic [BITMAP_W-1:0] bm;
        logic [LABEL_W-1:0]  lbl;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill every slot so no match reads an unwritten template
        for (int i = 0; i < N_TMPL; i++) begin
            bm  = rand64();
            lbl = LABEL_W'($urandom_range(0, 255));
            if (i == 0) lbl = 8'hFF;
            if (i == 63) lbl = 8'h00;
            if (i == 1) bm = '1;
            if (i == 2) bm = '0;
            if (i == 9) bm = gen_bits[7];   // duplicate of slot 7 for a tie
            queue_load(i, lbl, bm);
        end

        // Directed part at reset configuration
        queue_match('0, 1'b1);                     // exact hit on the all-zero template
        queue_match('1, 1'b1);                     // exact hit on the all-one template
        queue_match(gen_bits[7], 1'b1);            // tie between templates: lower slot wins
        queue_match(gen_bits[2] ^ 64'h7, 1'b0);    // later, higher score replaces
        queue_match(gen_bits[5], 1'b1);
        queue_match(gen_bits[1], 1'b0);            // equal score does not replace
        queue_match(gen_bits[2], 1'b1);
        queue_match(gen_bits[3] ^ rand64(), 1'b0); // load inside an open group
        queue_load(10, 8'h5A, rand64());
        queue_match(gen_bits[10], 1'b1);
        queue_match(rand64(), 1'b0);               // three-candidate group
        queue_match(rand64(), 1'b0);
        queue_match(rand64(), 1'b1);
        queue_load(63, 8'h00, '1);
        queue_load(0, 8'hFF, '0);
        queue_match('0, 1'b1);
        queue_match(64'h5555_5555_5555_5555, 1'b1);
        queue_match(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

        // Configuration sweep, extremes included
        run_phase(1, 1, 110, 1'b0, 1'b0);
        run_phase(0, 37, 60, 1'b0, 1'b0);
        run_phase(127, 127, 120, 1'b1, 1'b0);
        run_phase(64, 0, 60, 1'b0, 1'b0);
        run_phase(4, 64, 150, 1'b1, 1'b1);
        run_phase(33, 20, 120, 1'b0, 1'b0);
        run_phase(65, 64, 120, 1'b0, 1'b0);
        run_phase($urandom_range(1, 64), $urandom_range(1, 64), 120, 1'b0, 1'b0);
        run_phase(64, 64, 100, 1'b0, 1'b0);

        settle();
        if (n_errors == 0 && expected_best.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
